// ===== src/dsld_pkg.sv =====
package dsld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned STAT_W  = 2;

  localparam logic [BYTE_W-1:0] SYNC_BYTE      = 8'h68;
  localparam logic [POS_W-1:0]  FRAME_OVERHEAD = 17'd15;
  localparam logic [POS_W-1:0]  POS_SYNC2      = 17'd9;
  localparam logic [POS_W-1:0]  POS_CTRL       = 17'd10;
  localparam logic [POS_W-1:0]  POS_LEN_LO     = 17'd11;
  localparam logic [POS_W-1:0]  POS_LEN_HI     = 17'd12;
  localparam logic [POS_W-1:0]  POS_MIN_LAST   = 17'd14;

  localparam logic [STAT_W-1:0] STAT_HUNT     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FRAME    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SYNC_ERR = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic [STAT_W-1:0] status;
    logic [BYTE_W-1:0] ctrl;
    logic              last;
  } dsld_result_t;

endpackage

// ===== src/dsld_in_reg.sv =====
module dsld_in_reg
  import dsld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              adv_ready,
  output logic              adv_valid,
  output logic [BYTE_W-1:0] adv_byte
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  assign in_ready  = !valid_r || adv_ready;
  assign load      = in_valid && in_ready;
  assign adv_valid = valid_r;
  assign adv_byte  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (adv_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

// ===== src/dsld_core.sv =====
module dsld_core
  import dsld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [BYTE_W-1:0] rx_byte,
  output dsld_result_t      result
);

  logic              in_frame_r, in_frame_nxt;
  logic [POS_W-1:0]  byte_count_r, byte_count_nxt;
  logic [BYTE_W-1:0] len_low_r, len_low_nxt;
  logic [POS_W-1:0]  frame_total_r, frame_total_nxt;
  logic [BYTE_W-1:0] held_ctrl_r, held_ctrl_nxt;
  logic [POS_W-1:0]  pos_inc;

  assign pos_inc = byte_count_r + POS_W'(1);

  always_comb begin
    in_frame_nxt    = in_frame_r;
    byte_count_nxt  = byte_count_r;
    len_low_nxt     = len_low_r;
    frame_total_nxt = frame_total_r;
    held_ctrl_nxt   = held_ctrl_r;
    result.data     = rx_byte;
    result.pos      = '0;
    result.status   = STAT_HUNT;
    result.ctrl     = '0;
    result.last     = 1'b0;

    if (!in_frame_r) begin
      if (rx_byte == SYNC_BYTE) begin
        in_frame_nxt   = 1'b1;
        byte_count_nxt = POS_W'(1);
        result.status  = STAT_FRAME;
      end
    end else begin
      result.pos    = byte_count_r;
      result.status = STAT_FRAME;
      if (byte_count_r == POS_SYNC2 && rx_byte != SYNC_BYTE) begin
        result.status   = STAT_SYNC_ERR;
        in_frame_nxt    = 1'b0;
        byte_count_nxt  = '0;
        len_low_nxt     = '0;
        frame_total_nxt = '0;
        held_ctrl_nxt   = '0;
      end else begin
        if (byte_count_r == POS_CTRL) begin
          held_ctrl_nxt = rx_byte;
        end else if (byte_count_r == POS_LEN_LO) begin
          len_low_nxt = rx_byte;
        end else if (byte_count_r == POS_LEN_HI) begin
          // high byte weighs 256: a concatenation does it
          frame_total_nxt = POS_W'({rx_byte, len_low_r}) + FRAME_OVERHEAD;
        end
        result.ctrl = held_ctrl_nxt;
        if (byte_count_r >= POS_LEN_HI && pos_inc == frame_total_nxt) begin
          result.last     = 1'b1;
          in_frame_nxt    = 1'b0;
          byte_count_nxt  = '0;
          len_low_nxt     = '0;
          frame_total_nxt = '0;
          held_ctrl_nxt   = '0;
        end else begin
          byte_count_nxt = pos_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r    <= 1'b0;
      byte_count_r  <= '0;
      len_low_r     <= '0;
      frame_total_r <= '0;
      held_ctrl_r   <= '0;
    end else if (fire) begin
      in_frame_r    <= in_frame_nxt;
      byte_count_r  <= byte_count_nxt;
      len_low_r     <= len_low_nxt;
      frame_total_r <= frame_total_nxt;
      held_ctrl_r   <= held_ctrl_nxt;
    end
  end

endmodule

// ===== src/dsld_out_reg.sv =====
module dsld_out_reg
  import dsld_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  dsld_result_t result,
  output logic         stage_ready,
  output logic         out_valid,
  input  logic         out_ready,
  output dsld_result_t out_result
);

  logic         valid_r, valid_nxt;
  dsld_result_t result_r;

  assign stage_ready = !valid_r || out_ready;
  assign out_valid   = valid_r;
  assign out_result  = result_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

endmodule

// ===== src/double_sync_length_deframer.sv =====
// Frame receiver for a byte stream with a doubled 0x68 start and a length field.
// Input channel: in_valid / in_ready / in_rx_byte, one received word per handshake.
// Output channel: out_valid / out_ready and one result word for every input word:
//   the byte itself, its frame position, a status (hunting, frame byte, sync
//   error), the control code once position 10 has arrived, and a last mark on
//   the final byte of a complete frame (length field plus 15 bytes).
// Path: a word accepted on the in channel passes the input register, then the
//   frame tracker and the result register, before it shows on the out channel.
// Throughput: one word per cycle sustained while out_ready stays high; the frame
//   tracker updates in the single logic step between the two registers.
// Reset: synchronous, active low; both stages empty, tracker back to hunting
//   with position, length and control code cleared.
// Stall: when out_ready is low the result holds, the input register still takes
//   one more word, and in_ready drops once both stages are full. No word is lost.
module double_sync_length_deframer
  import dsld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_out_byte,
  output logic [POS_W-1:0]  out_frame_pos,
  output logic [STAT_W-1:0] out_byte_status,
  output logic [BYTE_W-1:0] out_ctrl_code,
  output logic              out_frame_last
);

  logic              adv_valid;
  logic              stage_ready;
  logic              fire;
  logic [BYTE_W-1:0] adv_byte;
  dsld_result_t      result;
  dsld_result_t      out_result;

  assign fire = adv_valid && stage_ready;

  dsld_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .adv_ready  (stage_ready),
    .adv_valid  (adv_valid),
    .adv_byte   (adv_byte)
  );

  dsld_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .rx_byte (adv_byte),
    .result  (result)
  );

  dsld_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (fire),
    .result      (result),
    .stage_ready (stage_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_result  (out_result)
  );

  assign out_out_byte    = out_result.data;
  assign out_frame_pos   = out_result.pos;
  assign out_byte_status = out_result.status;
  assign out_ctrl_code   = out_result.ctrl;
  assign out_frame_last  = out_result.last;

endmodule

// ===== src/dsld_checker.sv =====
module dsld_checker
  import dsld_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_out_byte,
  input logic [POS_W-1:0]  out_frame_pos,
  input logic [STAT_W-1:0] out_byte_status,
  input logic [BYTE_W-1:0] out_ctrl_code,
  input logic              out_frame_last
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_out_byte) &&
      $stable(out_frame_pos) && $stable(out_byte_status) &&
      $stable(out_ctrl_code) && $stable(out_frame_last))
    else $error("result word changed while stalled");

  a_sync_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_status == STAT_SYNC_ERR |->
      out_frame_pos == POS_SYNC2 && out_ctrl_code == '0 && !out_frame_last &&
      out_out_byte != SYNC_BYTE)
    else $error("sync error reported off the second start position");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_last |->
      out_byte_status == STAT_FRAME && out_frame_pos >= POS_MIN_LAST)
    else $error("frame end on a too short frame");

  a_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_status == STAT_HUNT |->
      out_frame_pos == '0 && out_ctrl_code == '0 && !out_frame_last &&
      out_out_byte != SYNC_BYTE)
    else $error("hunting word carries frame information");

endmodule

bind double_sync_length_deframer dsld_checker u_dsld_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_out_byte    (out_out_byte),
  .out_frame_pos   (out_frame_pos),
  .out_byte_status (out_byte_status),
  .out_ctrl_code   (out_ctrl_code),
  .out_frame_last  (out_frame_last)
);

// ===== tb/dsld_frame_checker.sv =====
`timescale 1ns / 100ps
module dsld_frame_checker
  import dsld_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [BYTE_W-1:0] out_out_byte,
  input  logic [POS_W-1:0]  out_frame_pos,
  input  logic [STAT_W-1:0] out_byte_status,
  input  logic [BYTE_W-1:0] out_ctrl_code,
  input  logic              out_frame_last,
  output int                error_count,
  output int                pending_words,
  output int                words_checked,
  output int                frames_closed,
  output int                sync_errors
);

  localparam int REPORT_LIMIT = 40;

  // tracker copy: hunting flag, next position, length bytes, control code
  logic              in_frame;
  logic [POS_W-1:0]  next_pos;
  logic [BYTE_W-1:0] len_low;
  logic [POS_W-1:0]  frame_len;
  logic [BYTE_W-1:0] held_ctrl;

  dsld_result_t expected_words[$];

  function automatic void back_to_hunt();
    in_frame  = 1'b0;
    next_pos  = '0;
    len_low   = '0;
    frame_len = '0;
    held_ctrl = '0;
  endfunction

  function automatic dsld_result_t deframe_byte(input logic [BYTE_W-1:0] b);
    dsld_result_t r;
    r      = '0;
    r.data = b;
    if (!in_frame) begin
      r.status = STAT_HUNT;
      if (b == SYNC_BYTE) begin
        in_frame = 1'b1;
        next_pos = 17'd1;
        r.status = STAT_FRAME;
      end
    end else begin
      r.pos    = next_pos;
      r.status = STAT_FRAME;
      if (r.pos == POS_SYNC2 && b != SYNC_BYTE) begin
        r.status = STAT_SYNC_ERR;
        back_to_hunt();
      end else begin
        if (r.pos == POS_CTRL) begin
          held_ctrl = b;
        end else if (r.pos == POS_LEN_LO) begin
          len_low = b;
        end else if (r.pos == POS_LEN_HI) begin
          frame_len = POS_W'(len_low) + POS_W'({b, 8'h00}) + FRAME_OVERHEAD;
        end
        r.ctrl = held_ctrl;
        // control code still shows on the closing byte
        if (r.pos >= POS_LEN_HI && r.pos + 17'd1 == frame_len) begin
          r.last = 1'b1;
          back_to_hunt();
        end else begin
          next_pos = r.pos + 17'd1;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [POS_W-1:0] want,
                             input logic [POS_W-1:0] got);
    if (want !== got) begin
      if (error_count < REPORT_LIMIT) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    dsld_result_t want;
    if (!rst_n) begin
      back_to_hunt();
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (error_count < REPORT_LIMIT) begin
            $display("%0t: result word with none expected, byte %0h pos %0h",
                     $time, out_out_byte, out_frame_pos);
          end
          error_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("out_byte", POS_W'(want.data), POS_W'(out_out_byte));
          check_field("frame_pos", want.pos, out_frame_pos);
          check_field("byte_status", POS_W'(want.status), POS_W'(out_byte_status));
          check_field("ctrl_code", POS_W'(want.ctrl), POS_W'(out_ctrl_code));
          check_field("frame_last", POS_W'(want.last), POS_W'(out_frame_last));
          words_checked++;
          if (want.last) frames_closed++;
          if (want.status == STAT_SYNC_ERR) sync_errors++;
        end
      end
      if (in_valid && in_ready) begin
        expected_words.push_back(deframe_byte(in_rx_byte));
      end
    end
    pending_words <= expected_words.size();
  end

endmodule

// ===== tb/double_sync_length_deframer_test.sv =====
`timescale 1ns / 100ps
module double_sync_length_deframer_test;
  import dsld_pkg::*;

  localparam int                FRAME_WORD_TARGET = 1050;
  localparam int                LAST_FRAME_LEN    = 256;
  localparam int                RX_HOLD_CYCLES    = 60;
  localparam int                IDLE_LIMIT        = 2000;
  localparam int                DRAIN_CYCLES      = 8;
  localparam logic [BYTE_W-1:0] END_BYTE          = 8'h16;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [BYTE_W-1:0] out_out_byte;
  logic [POS_W-1:0]  out_frame_pos;
  logic [STAT_W-1:0] out_byte_status;
  logic [BYTE_W-1:0] out_ctrl_code;
  logic              out_frame_last;

  int error_count;
  int pending_words;
  int words_checked;
  int frames_closed;
  int sync_errors;

  bit no_idle      = 1'b0;
  bit calm_frame   = 1'b0;
  bit hold_request = 1'b0;
  int frame_words  = 0;
  int idle_cycles  = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  double_sync_length_deframer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_frame_pos  (out_frame_pos),
    .out_byte_status(out_byte_status),
    .out_ctrl_code  (out_ctrl_code),
    .out_frame_last (out_frame_last)
  );

  dsld_frame_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_frame_pos  (out_frame_pos),
    .out_byte_status(out_byte_status),
    .out_ctrl_code  (out_ctrl_code),
    .out_frame_last (out_frame_last),
    .error_count    (error_count),
    .pending_words  (pending_words),
    .words_checked  (words_checked),
    .frames_closed  (frames_closed),
    .sync_errors    (sync_errors)
  );

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || calm_frame || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [BYTE_W-1:0] random_non_sync();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom); while (b == SYNC_BYTE);
    return b;
  endfunction

  // mostly short data fields, a few that need the high length byte
  function automatic logic [15:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 16'($urandom_range(0, 8));
    if (r < 85) return 16'($urandom_range(9, 64));
    if (r < 97) return 16'($urandom_range(65, 300));
    return 16'($urandom_range(256, 320));
  endfunction

  task automatic send_word(input logic [BYTE_W-1:0] b);
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // start, 8 address bytes, second start, ctrl, length, data, checksum, end
  task automatic send_frame(input logic [BYTE_W-1:0] ctrl, input logic [15:0] data_len,
                            input logic [BYTE_W-1:0] second_sync);
    send_word(SYNC_BYTE);
    repeat (8) send_word(BYTE_W'($urandom));
    send_word(second_sync);
    if (second_sync != SYNC_BYTE) begin
      frame_words += 10;
      return;
    end
    send_word(ctrl);
    send_word(data_len[7:0]);
    send_word(data_len[15:8]);
    repeat (data_len) send_word(BYTE_W'($urandom));
    send_word(BYTE_W'($urandom));
    send_word(END_BYTE);
    frame_words += 15 + int'(data_len);
  endtask

  initial begin
    int r;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(8'h00);
    send_word(8'hFF);
    send_word(SYNC_BYTE - 8'd1);
    send_word(SYNC_BYTE + 8'd1);
    frame_words += 4;
    send_frame(8'hFF, 16'd0, SYNC_BYTE);
    send_frame(8'h00, 16'd0, 8'h00);

    // back the block up: sender runs flat out while the receiver holds off
    no_idle      = 1'b1;
    hold_request = 1'b1;
    send_frame(BYTE_W'($urandom), 16'd40, SYNC_BYTE);
    no_idle = 1'b0;

    // leave room for the closing frame
    while (frame_words < FRAME_WORD_TARGET - 15 - LAST_FRAME_LEN) begin
      calm_frame = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(BYTE_W'($urandom), pick_length(), SYNC_BYTE);
      end else if (r < 85) begin
        send_frame(BYTE_W'($urandom), pick_length(), random_non_sync());
      end else begin
        r = $urandom_range(1, 6);
        repeat (r) send_word(random_non_sync());
        frame_words += r;
      end
    end

    calm_frame = 1'b1;
    send_frame(BYTE_W'($urandom), 16'(LAST_FRAME_LEN), SYNC_BYTE);
    in_valid <= 1'b0;

    do @(posedge clk); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d whole frames, %0d sync errors,", words_checked,
             frames_closed, sync_errors);
    $display("data lengths 0 to 320, hunting noise, random gaps and a long output stall.");
    if (error_count == 0 && pending_words == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    bit steady;
    int r;
    steady = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 999);
        if (r < 20) steady = !steady;
        if (r >= 990) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          out_ready <= steady || ($urandom_range(0, 99) < 70);
          @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
src/dsld_pkg.sv
src/dsld_in_reg.sv
src/dsld_core.sv
src/dsld_out_reg.sv
src/double_sync_length_deframer.sv
src/dsld_checker.sv
tb/dsld_frame_checker.sv
tb/double_sync_length_deframer_test.sv
